FILE: sv/assert_macros.svh
// Assertion macros shared by the flow color wheel RTL.
// Needs nothing but a clock and an active-low reset in the asserting scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, off during reset.
`define FCW_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Overlapping implication built on the macro above.
`define FCW_IMPLIES(name, clk, rst_n, ante, cons, msg) \
  `FCW_ASSERT(name, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: sv/fcw_pkg.sv
// Constants, CORDIC arctangent table and color wheel for the flow color block.
// No dependencies; used by fcw_cordic and flow_to_color_wheel.
package fcw_pkg;

  localparam int unsigned RadW      = 24;
  localparam int unsigned RnW       = 14;
  localparam int unsigned AngW      = 16;
  localparam int unsigned CordW     = 35;
  localparam int unsigned ZW        = 18;
  localparam int unsigned SqInW     = 20;
  localparam int unsigned MulAW     = 24;
  localparam int unsigned MulBW     = 20;
  localparam int unsigned KW        = 6;
  localparam int unsigned WheelMul  = 54;
  localparam int unsigned WheelSize = 55;
  localparam int unsigned RnOne     = 4096;

  typedef logic [WheelSize-1:0][23:0] wheel_tab_t;

  function automatic logic signed [ZW-1:0] atan_turn(input logic [3:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      4'd14:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic wheel_tab_t build_wheel();
    wheel_tab_t t;
    int kk;
    int r;
    int g;
    int b;
    t = '0;
    for (int k = 0; k < int'(WheelSize); k++) begin
      kk = k;
      if (kk < 15) begin
        r = 255; g = 255 * kk / 15; b = 0;
      end else if (kk < 21) begin
        kk = kk - 15; r = 255 - 255 * kk / 6; g = 255; b = 0;
      end else if (kk < 25) begin
        kk = kk - 21; r = 0; g = 255; b = 255 * kk / 4;
      end else if (kk < 36) begin
        kk = kk - 25; r = 0; g = 255 - 255 * kk / 11; b = 255;
      end else if (kk < 49) begin
        kk = kk - 36; r = 255 * kk / 13; g = 0; b = 255;
      end else begin
        kk = kk - 49;
        if (kk > 5) kk = 5;
        r = 255; g = 0; b = 255 - 255 * kk / 6;
      end
      t[k] = {8'(r), 8'(g), 8'(b)};
    end
    return t;
  endfunction

  localparam wheel_tab_t WheelTab = build_wheel();

  function automatic logic [7:0] wheel_color(input logic [KW-1:0] k, input logic [1:0] ch);
    logic [23:0] e;
    logic [7:0] v;
    e = WheelTab[k];
    case (ch)
      2'd0:    v = e[23:16];
      2'd1:    v = e[15:8];
      default: v = e[7:0];
    endcase
    return v;
  endfunction

endpackage

FILE: sv/fcw_in_if.sv
// Input channel of the flow color block: flow vector beat with pass control.
// Depends on nothing.
interface fcw_in_if #(parameter int FLOW_WIDTH = 16) ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic                         first;
  logic                         unknown;
  logic signed [FLOW_WIDTH-1:0] flow_x;
  logic signed [FLOW_WIDTH-1:0] flow_y;

  modport source (output valid, kind, first, unknown, flow_x, flow_y, input ready);
  modport sink (input valid, kind, first, unknown, flow_x, flow_y, output ready);
endinterface

FILE: sv/fcw_out_if.sv
// Output channel of the flow color block: one RGB pixel per beat.
// Depends on nothing.
interface fcw_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

FILE: sv/flow_to_color_wheel.sv
// Flow color wheel: each input beat takes a flow vector. A measure beat (kind 0) runs the
// squares and a 24-step square root; a color beat (kind 1) runs the squares, the square
// root, a 14-step divide and three channels of two multiplies each, the squares and channel
// multiplies all through one shared multiplier, with a CORDIC angle unit running beside the
// root. Unknown vectors and a zero maximum skip the arithmetic. A new beat is taken while the
// last pixel still waits.
// Depends on fcw_pkg, fcw_in_if, fcw_out_if, fcw_cordic and assert_macros.svh.
`include "assert_macros.svh"

module flow_to_color_wheel #(
  parameter int FLOW_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  fcw_in_if.sink    in_i,
  fcw_out_if.source out_o
);

  localparam int W = FLOW_WIDTH;
  localparam int RW = fcw_pkg::RadW;
  localparam int NW = fcw_pkg::RnW;
  localparam int AW = fcw_pkg::MulAW;
  localparam int BW = fcw_pkg::MulBW;
  localparam int KW = fcw_pkg::KW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQX  = 4'd1;
  localparam logic [3:0] S_SQY  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_RAD  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_WAIT = 4'd6;
  localparam logic [3:0] S_BLD  = 4'd7;
  localparam logic [3:0] S_SHD  = 4'd8;
  localparam logic [3:0] S_PUT  = 4'd9;

  logic [3:0] state_q, state_d;
  logic kind_q, kind_d, sat_q, sat_d, big_q, big_d;
  logic [W-1:0] ax_q, ax_d, ay_q, ay_d;
  logic [39:0] sq_q, sq_d;
  logic [47:0] v_q, v_d;
  logic [26:0] rem_q, rem_d;
  logic [RW-1:0] root_q, root_d, max_q, max_d, rdiv_q, rdiv_d;
  logic [13:0] dbits_q, dbits_d;
  logic [NW-1:0] rn_q, rn_d;
  logic [4:0] cnt_q, cnt_d;
  logic [KW-1:0] k0_q, k0_d;
  logic [15:0] f_q, f_d;
  logic [1:0] ch_q, ch_d;
  logic [23:0] blend_q, blend_d;
  logic [7:0] pix_q [3];
  logic [7:0] pix_d [3];
  logic out_valid_q;
  logic [7:0] red_q, green_q, blue_q;

  logic acc, put, ang_start, ang_done;
  logic [fcw_pkg::AngW-1:0] angle;
  logic [W-1:0] ax_in, ay_in;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [AW+BW-1:0] prod;
  logic [40:0] s;
  logic [26:0] rem2, trial;
  logic [24:0] r2;
  logic [21:0] p;
  logic [KW-1:0] k1;
  logic [7:0] c0, c1;
  logic [35:0] dark;
  logic [25:0] tri3;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc = in_i.valid && in_i.ready;
  assign put = (state_q == S_PUT) && (!out_valid_q || out_o.ready);
  assign ang_start = acc && in_i.kind && !in_i.unknown && (max_q != '0);

  assign ax_in = in_i.flow_x[W-1] ? (~in_i.flow_x) + W'(1) : in_i.flow_x;
  assign ay_in = in_i.flow_y[W-1] ? (~in_i.flow_y) + W'(1) : in_i.flow_y;

  fcw_cordic #(.FLOW_WIDTH(FLOW_WIDTH)) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ang_start),
    .flow_x_i (in_i.flow_x),
    .flow_y_i (in_i.flow_y),
    .done_o   (ang_done),
    .angle_o  (angle)
  );

  assign k1 = (k0_q == KW'(fcw_pkg::WheelMul)) ? '0 : k0_q + KW'(1);
  assign c0 = fcw_pkg::wheel_color(k0_q, ch_q);
  assign c1 = fcw_pkg::wheel_color(k1, ch_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQX: begin
        mul_a = AW'(BW'(ax_q));
        mul_b = BW'(ax_q);
      end
      S_SQY: begin
        mul_a = AW'(BW'(ay_q));
        mul_b = BW'(ay_q);
      end
      S_BLD: begin
        mul_a = AW'((c1 >= c0) ? c1 - c0 : c0 - c1);
        mul_b = BW'(f_q);
      end
      S_SHD: begin
        mul_a = 24'hFF0000 - blend_q;
        mul_b = BW'(rn_q);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign s = {1'b0, sq_q} + prod[40:0];
  assign rem2 = {rem_q[24:0], v_q[47:46]};
  assign trial = {1'b0, root_q, 2'b01};
  assign r2 = {rdiv_q, dbits_q[13]};
  assign p = 22'(angle) * 22'(fcw_pkg::WheelMul);
  assign dark = 36'hFF0000000 - prod[35:0];
  assign tri3 = {1'b0, blend_q, 1'b0} + {2'b00, blend_q};

  always_comb begin
    state_d = state_q;
    kind_d = kind_q;
    sat_d = sat_q;
    big_d = big_q;
    ax_d = ax_q;
    ay_d = ay_q;
    sq_d = sq_q;
    v_d = v_q;
    rem_d = rem_q;
    root_d = root_q;
    max_d = max_q;
    rdiv_d = rdiv_q;
    dbits_d = dbits_q;
    rn_d = rn_q;
    cnt_d = cnt_q;
    k0_d = k0_q;
    f_d = f_q;
    ch_d = ch_q;
    blend_d = blend_q;
    pix_d = pix_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          kind_d = in_i.kind;
          ax_d = ax_in;
          ay_d = ay_in;
          sat_d = ((ax_in >> fcw_pkg::SqInW) != '0) || ((ay_in >> fcw_pkg::SqInW) != '0);
          if (!in_i.kind) begin
            if (in_i.first) max_d = '0;
            if (!in_i.unknown) state_d = S_SQX;
          end else if (in_i.unknown) begin
            pix_d = '{8'h00, 8'h00, 8'h00};
            state_d = S_PUT;
          end else if (max_q == '0) begin
            pix_d = '{8'hFF, 8'hFF, 8'hFF};
            state_d = S_PUT;
          end else begin
            state_d = S_SQX;
          end
        end
      end
      S_SQX: begin
        sq_d = prod[39:0];
        state_d = S_SQY;
      end
      S_SQY: begin
        v_d = {s[39:0], 8'h00};
        rem_d = '0;
        root_d = '0;
        cnt_d = '0;
        if (sat_q || s[40]) begin
          root_d = '1;
          state_d = S_RAD;
        end else begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        v_d = {v_q[45:0], 2'b00};
        if (rem2 >= trial) begin
          rem_d = rem2 - trial;
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          rem_d = rem2;
          root_d = {root_q[RW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(RW - 1)) state_d = S_RAD;
      end
      S_RAD: begin
        if (!kind_q) begin
          if (root_q > max_q) max_d = root_q;
          state_d = S_IDLE;
        end else begin
          big_d = {2'b00, root_q} >= {max_q, 2'b00};
          rdiv_d = {2'b00, root_q[RW-1:2]};
          dbits_d = {root_q[1:0], 12'h000};
          rn_d = '0;
          cnt_d = '0;
          state_d = big_d ? S_WAIT : S_DIV;
        end
      end
      S_DIV: begin
        dbits_d = {dbits_q[12:0], 1'b0};
        if (r2 >= {1'b0, max_q}) begin
          rdiv_d = RW'(r2 - {1'b0, max_q});
          rn_d = {rn_q[NW-2:0], 1'b1};
        end else begin
          rdiv_d = r2[RW-1:0];
          rn_d = {rn_q[NW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(NW - 1)) state_d = S_WAIT;
      end
      S_WAIT: begin
        if (ang_done) begin
          k0_d = p[21:16];
          f_d = p[15:0];
          ch_d = '0;
          state_d = S_BLD;
        end
      end
      S_BLD: begin
        blend_d = (c1 >= c0) ? {c0, 16'h0000} + prod[23:0] : {c0, 16'h0000} - prod[23:0];
        state_d = S_SHD;
      end
      S_SHD: begin
        if (!big_q && (rn_q <= NW'(fcw_pkg::RnOne))) pix_d[ch_q] = dark[35:28];
        else pix_d[ch_q] = tri3[25:18];
        ch_d = ch_q + 2'd1;
        state_d = (ch_q == 2'd2) ? S_PUT : S_BLD;
      end
      S_PUT: begin
        if (put) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      max_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      max_q <= max_d;
      if (put) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    sat_q <= sat_d;
    big_q <= big_d;
    ax_q <= ax_d;
    ay_q <= ay_d;
    sq_q <= sq_d;
    v_q <= v_d;
    rem_q <= rem_d;
    root_q <= root_d;
    rdiv_q <= rdiv_d;
    dbits_q <= dbits_d;
    rn_q <= rn_d;
    cnt_q <= cnt_d;
    k0_q <= k0_d;
    f_q <= f_d;
    ch_q <= ch_d;
    blend_q <= blend_d;
    pix_q <= pix_d;
    if (put) begin
      red_q <= pix_q[0];
      green_q <= pix_q[1];
      blue_q <= pix_q[2];
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.red = red_q;
  assign out_o.green = green_q;
  assign out_o.blue = blue_q;

  `FCW_IMPLIES(a_out_from_put, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == S_PUT, "pixel without put")
  `FCW_IMPLIES(a_blend_has_angle, clk_i, rst_ni, state_q == S_BLD, ang_done, "blend before angle")
  `FCW_IMPLIES(a_max_source, clk_i, rst_ni, max_q != $past(max_q), ($past(state_q) == S_RAD) || $past(acc), "max changed")

endmodule

FILE: sv/fcw_cordic.sv
// Iterative CORDIC angle unit: flow direction in 1/65536 turn.
// Depends on fcw_pkg.
module fcw_cordic #(
  parameter int FLOW_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [FLOW_WIDTH-1:0] flow_x_i,
  input  logic signed [FLOW_WIDTH-1:0] flow_y_i,
  output logic                         done_o,
  output logic [fcw_pkg::AngW-1:0]     angle_o
);

  localparam int W = FLOW_WIDTH;
  localparam int CW = fcw_pkg::CordW;
  localparam int ZW = fcw_pkg::ZW;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ROT  = 2'd2;
  localparam logic [1:0] C_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic signed [CW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic [3:0] i_q, i_d;
  logic sx_q, sx_d, sy_q, sy_d;

  logic [W-1:0] ax, ay;
  logic signed [CW-1:0] m, xs, ys, xneg, yneg;
  logic signed [ZW-1:0] zc;
  logic [16:0] ang;

  assign ax = flow_x_i[W-1] ? (~flow_x_i) + W'(1) : flow_x_i;
  assign ay = flow_y_i[W-1] ? (~flow_y_i) + W'(1) : flow_y_i;
  assign m = (x_q > y_q) ? x_q : y_q;

  assign xneg = -x_q;
  assign yneg = -y_q;
  assign xs = x_q[CW-1] ? -(xneg >>> i_q) : (x_q >>> i_q);
  assign ys = y_q[CW-1] ? -(yneg >>> i_q) : (y_q >>> i_q);

  always_comb begin
    state_d = state_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    i_d = i_q;
    sx_d = sx_q;
    sy_d = sy_q;
    if (start_i) begin
      sx_d = flow_x_i[W-1];
      sy_d = flow_y_i[W-1];
      x_d = CW'(ax);
      y_d = CW'(ay);
      z_d = '0;
      i_d = '0;
      state_d = (ax == '0 && ay == '0) ? C_DONE : C_NORM;
    end else begin
      case (state_q)
        C_NORM: begin
          if ((m >>> 21) == '0) begin
            x_d = x_q <<< 8;
            y_d = y_q <<< 8;
          end else if ((m >>> 29) == '0) begin
            x_d = x_q <<< 1;
            y_d = y_q <<< 1;
          end else begin
            state_d = C_ROT;
          end
        end
        C_ROT: begin
          if (y_q > 0) begin
            x_d = x_q + ys;
            y_d = y_q - xs;
            z_d = z_q + fcw_pkg::atan_turn(i_q);
          end else begin
            x_d = x_q - ys;
            y_d = y_q + xs;
            z_d = z_q - fcw_pkg::atan_turn(i_q);
          end
          i_d = i_q + 4'd1;
          if (i_q == 4'd15) state_d = C_DONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    i_q <= i_d;
    sx_q <= sx_d;
    sy_q <= sy_d;
  end

  always_comb begin
    if (z_q < 0) zc = '0;
    else if (z_q > 18'sd16384) zc = 18'sd16384;
    else zc = z_q;
    case ({sx_q, sy_q})
      2'b00:   ang = zc[16:0];
      2'b10:   ang = 17'd32768 - zc[16:0];
      2'b11:   ang = 17'd32768 + zc[16:0];
      default: ang = 17'd65536 - zc[16:0];
    endcase
  end

  assign angle_o = ang[15:0];
  assign done_o = (state_q == C_DONE);

endmodule
